// ===== hw/rtl/swic_pkg.sv =====
// Shared constants and types for the sliding window id cache.
package swic_pkg;

  // Field widths of the item channels
  localparam int OP_W   = 2;
  localparam int ID_W   = 32;
  localparam int DATA_W = 32;

  // Defaults for the top-level parameters
  localparam int ENTRIES_DEF       = 96;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  // Base id after reset
  localparam logic [ID_W-1:0] BASE_RESET = 32'd1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the accepted item and its window offset
    logic exec;     // run the item against the window and load the result
  } swic_cmd_t;

endpackage

// ===== hw/rtl/swic_ctrl.sv =====
// Controller: handshake and sequencing of one item at a time.
module swic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output swic_pkg::swic_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  // Take an item only when the result register is free or drains this cycle
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // Next state and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign cmd.capture = accept;
  assign cmd.exec    = (state_r == ST_EXEC);

endmodule

// ===== hw/rtl/swic_dp.sv =====
// Datapath: window base, ring head, slot valid bits, payload memory, result.
module swic_dp #(
  parameter int ENTRIES       = swic_pkg::ENTRIES_DEF,
  parameter int PAYLOAD_WIDTH = swic_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  swic_pkg::swic_cmd_t         cmd,
  input  logic [swic_pkg::OP_W-1:0]   in_op,
  input  logic [swic_pkg::ID_W-1:0]   in_id,
  input  logic [swic_pkg::DATA_W-1:0] in_payload,
  output logic                        out_hit,
  output logic [swic_pkg::DATA_W-1:0] out_data,
  output logic [swic_pkg::ID_W-1:0]   out_window_base
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int ID_W  = swic_pkg::ID_W;

  // Window state
  logic [ID_W-1:0]    base_r, base_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;

  // Captured item
  logic [swic_pkg::OP_W-1:0] op_r;
  logic [ID_W-1:0]           id_r;
  logic [ID_W-1:0]           d_r;
  logic [PAYLOAD_WIDTH-1:0]  payload_r;

  // Result
  logic                     hit_r;
  logic                     rdhit_r;
  logic [PAYLOAD_WIDTH-1:0] rd_data_r;

  // Payload store
  logic [PAYLOAD_WIDTH-1:0] mem [ENTRIES];

  logic               is_add, is_read, is_del;
  logic               behind, in_win, ahead;
  logic [CNT_W-1:0]   shift;
  logic [SUM_W-1:0]   head_sum, win_sum;
  logic [IDX_W-1:0]   win_idx, phys;
  logic               add_ok, read_hit;
  logic [ENTRIES-1:0] clr;

  // Classify the item against the window
  assign is_add  = (op_r == swic_pkg::OP_ADD);
  assign is_read = (op_r == swic_pkg::OP_READ);
  assign is_del  = (op_r == swic_pkg::OP_DEL);
  assign behind  = d_r[ID_W-1];
  assign in_win  = (d_r < ID_W'(ENTRIES));
  assign ahead   = !behind && !in_win;

  // Number of slots leaving the window, clamped to the window size
  always_comb begin
    shift = '0;
    if (is_del && !behind) begin
      if (d_r >= ID_W'(ENTRIES - 1)) begin
        shift = CNT_W'(ENTRIES);
      end else begin
        shift = CNT_W'(d_r + ID_W'(1));
      end
    end else if (is_add && ahead) begin
      if (d_r >= ID_W'(2 * ENTRIES - 1)) begin
        shift = CNT_W'(ENTRIES);
      end else begin
        shift = CNT_W'(d_r - ID_W'(ENTRIES - 1));
      end
    end
  end

  // New ring head
  assign head_sum = SUM_W'(head_r) + SUM_W'(shift);
  always_comb begin
    if (head_sum >= SUM_W'(ENTRIES)) begin
      head_nxt = IDX_W'(head_sum - SUM_W'(ENTRIES));
    end else begin
      head_nxt = IDX_W'(head_sum);
    end
  end

  // Physical slot: last slot after an advancing add, else head plus offset
  assign win_sum = SUM_W'(head_r) + SUM_W'(IDX_W'(d_r));
  always_comb begin
    if (win_sum >= SUM_W'(ENTRIES)) begin
      win_idx = IDX_W'(win_sum - SUM_W'(ENTRIES));
    end else begin
      win_idx = IDX_W'(win_sum);
    end
    if (ahead) begin
      phys = (head_nxt == '0) ? IDX_W'(ENTRIES - 1) : head_nxt - IDX_W'(1);
    end else begin
      phys = win_idx;
    end
  end

  // An advancing add always lands on a slot that was just cleared
  assign add_ok   = is_add && !behind && (ahead || !valid_r[phys]);
  assign read_hit = is_read && in_win && valid_r[phys];

  // Clear mask: slots within shift positions of the old head
  always_comb begin
    logic [SUM_W-1:0] off;
    off = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (IDX_W'(i) >= head_r) begin
        off = SUM_W'(i) - SUM_W'(head_r);
      end else begin
        off = SUM_W'(i) + SUM_W'(ENTRIES) - SUM_W'(head_r);
      end
      clr[i] = (off < SUM_W'(shift));
    end
  end

  always_comb begin
    valid_nxt = valid_r & ~clr;
    if (add_ok) begin
      valid_nxt[phys] = 1'b1;
    end
  end

  // New base id
  always_comb begin
    base_nxt = base_r;
    if (is_del && !behind) begin
      base_nxt = id_r + ID_W'(1);
    end else if (is_add && ahead) begin
      base_nxt = id_r - ID_W'(ENTRIES - 1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= swic_pkg::BASE_RESET;
      head_r  <= '0;
      valid_r <= '0;
      hit_r   <= 1'b0;
      rdhit_r <= 1'b0;
    end else if (cmd.exec) begin
      base_r  <= base_nxt;
      head_r  <= head_nxt;
      valid_r <= valid_nxt;
      hit_r   <= add_ok || read_hit;
      rdhit_r <= read_hit;
    end
  end

  // Item capture with its offset from the base
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_op;
      id_r      <= in_id;
      d_r       <= in_id - base_r;
      payload_r <= PAYLOAD_WIDTH'(in_payload);
    end
  end

  // Payload memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && add_ok) begin
      mem[phys] <= payload_r;
    end
    if (cmd.exec) begin
      rd_data_r <= mem[phys];
    end
  end

  assign out_hit         = hit_r;
  assign out_data        = rdhit_r ? swic_pkg::DATA_W'(rd_data_r) : '0;
  assign out_window_base = base_r;

endmodule

// ===== hw/rtl/sliding_window_id_cache.sv =====
// Top level of the sliding window id cache.
// An accepted item is captured, then run against the window in the exec
//   state (ring update plus the payload memory read), and its result is
//   registered; no new item is taken in the exec state.
// A new item is taken while the previous result is handed off.
// Reset: base id 1, every slot empty, ready the cycle after reset.
module sliding_window_id_cache #(
  parameter int ENTRIES       = swic_pkg::ENTRIES_DEF,
  parameter int PAYLOAD_WIDTH = swic_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [swic_pkg::OP_W-1:0]   in_op,
  input  logic [swic_pkg::ID_W-1:0]   in_id,
  input  logic [swic_pkg::DATA_W-1:0] in_payload,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [swic_pkg::DATA_W-1:0] out_data,
  output logic [swic_pkg::ID_W-1:0]   out_window_base
);

  swic_pkg::swic_cmd_t cmd;

  swic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  swic_dp #(
    .ENTRIES       (ENTRIES),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_op),
    .in_id           (in_id),
    .in_payload      (in_payload),
    .out_hit         (out_hit),
    .out_data        (out_data),
    .out_window_base (out_window_base)
  );

endmodule

// ===== hw/rtl/swic_chk.sv =====
// Port-level checks for the sliding window id cache, bound to the top level.
module swic_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [swic_pkg::OP_W-1:0]   in_op,
  input logic [swic_pkg::ID_W-1:0]   in_id,
  input logic [swic_pkg::DATA_W-1:0] in_payload,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_hit,
  input logic [swic_pkg::DATA_W-1:0] out_data,
  input logic [swic_pkg::ID_W-1:0]   out_window_base
);

  // A waiting input item holds its fields
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=>
      in_valid && $stable(in_op) && $stable(in_id) && $stable(in_payload))
    else $error("input item changed while waiting");

  // A stalled result holds its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_hit) && $stable(out_data) && $stable(out_window_base))
    else $error("result changed while stalled");

  // Each accepted item yields its result: out_valid stays low while it executes, then rises
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid ##1 out_valid)
    else $error("result not delivered two cycles after accept");

  // No new item while a result waits and is not taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item accepted over a pending result");

  // Nonzero data only comes with a hit
  a_data_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data != '0) |-> out_hit)
    else $error("data without hit");

endmodule

bind sliding_window_id_cache swic_chk u_swic_chk (.*);
